@@ src/sret_pkg.sv @@
// Package for the segment raycast edge table: shared widths, defaults, result and command codes.
// Used by segment_raycast_edge_table and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sret_pkg;

	localparam int COORD_W       = 16;
	localparam int MAX_EDGES_DEF = 64;
	localparam int IDX_OUT_W     = 6;
	localparam int HNUM_W        = 7;

	// result status codes
	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_HIT    = 2'd2;
	localparam logic [1:0] ST_NOHIT  = 2'd3;

	// command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_CAST = 1'b1;

endpackage

@@ src/segment_raycast_edge_table.sv @@
// Edge table with segment raycast: one shared multiplier and one restoring divider step
// under a sequencer. Depends on sret_pkg.
// Add: result in the output register the cycle after accept.
// Raycast: per stored edge NEXT, DIFF, the MUL steps and CHK; on a hit, MX and the 17-step
// quotient loop, run once per axis, then HIT; FIN loads the item's last result.
// One item at a time; input is stalled until the item's last result is loaded.
// Reset clears the edge count, sequencer and output valid; table contents are kept.
`timescale 1ns / 1ps

module segment_raycast_edge_table
	import sret_pkg::*;
#(
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic signed [COORD_W-1:0]   start_x,
	input  logic signed [COORD_W-1:0]   start_y,
	input  logic signed [COORD_W-1:0]   end_x,
	input  logic signed [COORD_W-1:0]   end_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [IDX_OUT_W-1:0]        edge_index,
	output logic signed [COORD_W-1:0]   hit_x,
	output logic signed [COORD_W-1:0]   hit_y,
	output logic [HNUM_W-1:0]           hit_number,
	output logic                        last
);

	localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int DW = COORD_W + 1;        // coordinate difference
	localparam int PW = 2 * DW + 1;         // sum of two cross products
	localparam int MA = PW + 1;             // multiplier operand a
	localparam int MB = DW + 1;             // multiplier operand b
	localparam int RW = PW + DW;            // dividend / remainder
	localparam int SW = $clog2(DW);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NEXT = 4'd1;
	localparam logic [3:0] S_DIFF = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_MX   = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_HIT  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [CW-1:0] count_q, idx_q, hnum_q;
	logic [2:0] step_q;
	logic axis_q;
	logic [SW-1:0] cnt_q;

	logic [4*COORD_W-1:0] mem [MAX_EDGES];
	logic [4*COORD_W-1:0] rd_q;

	logic signed [COORD_W-1:0] a1x_q, a1y_q;
	logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, ex_q, ey_q;
	logic signed [PW-1:0] acc_q, den_q, tn_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic signed [COORD_W-1:0] hx_q, hy_q;

	logic pend_q;
	logic [CW-1:0] pidx_q, pnum_q;
	logic signed [COORD_W-1:0] phx_q, phy_q;

	logic out_free, take;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);
	assign take     = in_valid && !in_stall;

	// shared multiplier operand select
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [MA+MB-1:0] prod;
	logic [DW-1:0] absd;
	logic negd;
	always_comb begin
		negd = axis_q ? (day_q > 0) : (dax_q > 0);
		absd = axis_q ? (day_q[DW-1] ? DW'(-day_q) : DW'(day_q))
		              : (dax_q[DW-1] ? DW'(-dax_q) : DW'(dax_q));
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MX) begin
			mul_a = MA'(tn_q);
			mul_b = MB'($signed({1'b0, absd}));
		end else begin
			case (step_q)
				3'd0: begin mul_a = MA'(dax_q); mul_b = MB'(dby_q); end
				3'd1: begin mul_a = MA'(day_q); mul_b = MB'(dbx_q); end
				3'd2: begin mul_a = MA'(ex_q);  mul_b = MB'(dby_q); end
				3'd3: begin mul_a = MA'(ey_q);  mul_b = MB'(dbx_q); end
				3'd4: begin mul_a = MA'(day_q); mul_b = MB'(ex_q);  end
				default: begin mul_a = MA'(dax_q); mul_b = MB'(ey_q); end
			endcase
		end
		prod = mul_a * mul_b;
	end

	// sign normalize and range check
	logic signed [PW-1:0] den_n, tn_n, un_n;
	logic hit_ok;
	always_comb begin
		den_n = den_q[PW-1] ? -den_q : den_q;
		tn_n  = den_q[PW-1] ? -tn_q  : tn_q;
		un_n  = den_q[PW-1] ? -acc_q : acc_q;
		hit_ok = (den_q != '0) && (tn_n >= 0) && (tn_n <= den_n)
		         && (un_n >= 0) && (un_n <= den_n);
	end

	// restoring divider step
	logic [RW-1:0] den_sh;
	logic ge;
	logic [DW-1:0] quo_f;
	logic signed [COORD_W+1:0] coord;
	always_comb begin
		den_sh = RW'(den_q) << cnt_q;
		ge = rem_q >= den_sh;
		quo_f = quo_q | (ge ? (DW'(1) << cnt_q) : '0);
		coord = (COORD_W+2)'(axis_q ? a1y_q : a1x_q)
		        + (negd ? -(COORD_W+2)'(quo_f) : (COORD_W+2)'(quo_f));
	end

	// edge table storage
	always_ff @(posedge clk) begin
		if (take && cmd == CMD_ADD && count_q < CW'(MAX_EDGES))
			mem[count_q[IW-1:0]] <= {end_y, end_x, start_y, start_x};
		if (state_q == S_NEXT)
			rd_q <= mem[idx_q[IW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (cmd == CMD_ADD) begin
							out_valid  <= 1'b1;
							hit_x      <= '0;
							hit_y      <= '0;
							hit_number <= '0;
							last       <= 1'b1;
							if (count_q < CW'(MAX_EDGES)) begin
								status     <= ST_STORED;
								edge_index <= IDX_OUT_W'(count_q);
								count_q    <= count_q + 1'b1;
							end else begin
								status     <= ST_FULL;
								edge_index <= '0;
							end
						end else begin
							a1x_q   <= start_x;
							a1y_q   <= start_y;
							dax_q   <= DW'(start_x) - DW'(end_x);
							day_q   <= DW'(start_y) - DW'(end_y);
							idx_q   <= '0;
							hnum_q  <= '0;
							pend_q  <= 1'b0;
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					state_q <= (idx_q == count_q) ? S_FIN : S_DIFF;
				end
				S_DIFF: begin
					dbx_q   <= DW'($signed(rd_q[15:0])) - DW'($signed(rd_q[47:32]));
					dby_q   <= DW'($signed(rd_q[31:16])) - DW'($signed(rd_q[63:48]));
					ex_q    <= DW'(a1x_q) - DW'($signed(rd_q[15:0]));
					ey_q    <= DW'(a1y_q) - DW'($signed(rd_q[31:16]));
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// accumulate pairs: den, tn, then un
					if (!step_q[0]) begin
						acc_q <= PW'(prod);
					end else begin
						acc_q <= acc_q - PW'(prod);
						if (step_q == 3'd1)
							den_q <= acc_q - PW'(prod);
						if (step_q == 3'd3)
							tn_q <= acc_q - PW'(prod);
					end
					if (step_q == 3'd4) begin
						acc_q <= PW'(prod);
					end
					if (step_q == 3'd5) begin
						// un = day*ex - dax*ey
						acc_q   <= acc_q - PW'(prod);
						state_q <= S_CHK;
					end
					step_q <= step_q + 1'b1;
				end
				S_CHK: begin
					if (hit_ok) begin
						den_q   <= den_n;
						tn_q    <= tn_n;
						axis_q  <= 1'b0;
						state_q <= S_MX;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_MX: begin
					rem_q   <= RW'(prod);
					quo_q   <= '0;
					cnt_q   <= SW'(DW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (ge)
						rem_q <= rem_q - den_sh;
					quo_q <= quo_f;
					if (cnt_q == '0) begin
						if (!axis_q) begin
							hx_q    <= coord[COORD_W-1:0];
							axis_q  <= 1'b1;
							state_q <= S_MX;
						end else begin
							hy_q    <= coord[COORD_W-1:0];
							state_q <= S_HIT;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_HIT: begin
					// push the held hit, then hold the new one
					if (!pend_q || out_free) begin
						if (pend_q) begin
							out_valid  <= 1'b1;
							status     <= ST_HIT;
							edge_index <= IDX_OUT_W'(pidx_q);
							hit_x      <= phx_q;
							hit_y      <= phy_q;
							hit_number <= HNUM_W'(pnum_q);
							last       <= 1'b0;
						end
						pend_q  <= 1'b1;
						pidx_q  <= idx_q;
						pnum_q  <= hnum_q + 1'b1;
						phx_q   <= hx_q;
						phy_q   <= hy_q;
						hnum_q  <= hnum_q + 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						last      <= 1'b1;
						if (pend_q) begin
							status     <= ST_HIT;
							edge_index <= IDX_OUT_W'(pidx_q);
							hit_x      <= phx_q;
							hit_y      <= phy_q;
							hit_number <= HNUM_W'(pnum_q);
						end else begin
							status     <= ST_NOHIT;
							edge_index <= '0;
							hit_x      <= '0;
							hit_y      <= '0;
							hit_number <= '0;
						end
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ test/testbench.sv @@
// Self-checking bench for segment_raycast_edge_table: it fills and overfills the edge table
// and raycasts against it. Each result beat is checked against a built-in predictor.
// Depends on sret_pkg and segment_raycast_edge_table.
`timescale 1ns / 1ps

module testbench;
	import sret_pkg::*;

	typedef struct packed {
		logic              cmd;
		logic signed [15:0] sx, sy, ex, ey;
	} seg_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         idx;
		logic signed [15:0] hx, hy;
		logic [6:0]         num;
		logic               last;
	} seg_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [5:0] edge_index;
	logic signed [15:0] hit_x, hit_y;
	logic [6:0] hit_number;
	logic last;

	seg_cmd_t pending_cmds[$];
	seg_res_t expected_results[$];
	seg_cmd_t wall_model[64];
	int wall_count = 0;
	int mismatches = 0;
	int beats_seen = 0;
	int hits_seen = 0;
	int full_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit hold_sender = 1'b0;
	bit stim_done = 1'b0;
	int stall_phase = 0;

	segment_raycast_edge_table i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.edge_index(edge_index), .hit_x(hit_x), .hit_y(hit_y),
		.hit_number(hit_number), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Intersect query a1-a2 with wall b1-b2; exact products, quotient truncated toward zero.
	function automatic bit cross_wall(seg_cmd_t q, seg_cmd_t w, output logic signed [15:0] px,
			output logic signed [15:0] py);
		longint a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y, den, tn, un;
		a1x = q.sx; a1y = q.sy; a2x = q.ex; a2y = q.ey;
		b1x = w.sx; b1y = w.sy; b2x = w.ex; b2y = w.ey;
		px = '0;
		py = '0;
		den = (a1x - a2x) * (b1y - b2y) - (a1y - a2y) * (b1x - b2x);
		tn = (a1x - b1x) * (b1y - b2y) - (a1y - b1y) * (b1x - b2x);
		un = -((a1x - a2x) * (a1y - b1y) - (a1y - a2y) * (a1x - b1x));
		if (den == 0) return 1'b0;
		if (den < 0) begin
			den = -den;
			tn = -tn;
			un = -un;
		end
		if (tn < 0 || tn > den || un < 0 || un > den) return 1'b0;
		px = 16'(a1x + (tn * (a2x - a1x)) / den);
		py = 16'(a1y + (tn * (a2y - a1y)) / den);
		return 1'b1;
	endfunction

	// Update the wall table and queue the results one command produces.
	task automatic predict_walls(seg_cmd_t c);
		seg_res_t r;
		logic signed [15:0] px, py;
		int n;
		n = 0;
		if (c.cmd == CMD_ADD) begin
			r = '{status: ST_FULL, idx: '0, hx: '0, hy: '0, num: '0, last: 1'b1};
			if (wall_count < 64) begin
				wall_model[wall_count] = c;
				r.status = ST_STORED;
				r.idx = 6'(wall_count);
				wall_count++;
			end
			expected_results.push_back(r);
		end else begin
			for (int i = 0; i < wall_count; i++) begin
				if (cross_wall(c, wall_model[i], px, py)) begin
					n++;
					r = '{status: ST_HIT, idx: 6'(i), hx: px, hy: py, num: 7'(n), last: 1'b0};
					expected_results.push_back(r);
				end
			end
			if (n == 0) begin
				r = '{status: ST_NOHIT, idx: '0, hx: '0, hy: '0, num: '0, last: 1'b1};
				expected_results.push_back(r);
			end else begin
				expected_results[$].last = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on beat %0d: %s got %0d want %0d", beats_seen, what, got, want);
		mismatches++;
	endtask

	function automatic seg_cmd_t make_cmd(logic c, int sx, int sy, int ex, int ey);
		return '{cmd: c, sx: 16'(sx), sy: 16'(sy), ex: 16'(ex), ey: 16'(ey)};
	endfunction

	// Random coordinate: mostly a mid range that crosses often, sometimes any value.
	function automatic int rand_coord();
		if ($urandom_range(0, 5) == 0) return $signed(16'($urandom()));
		return $urandom_range(0, 1600) - 800;
	endfunction

	function automatic seg_cmd_t rand_cmd(logic c);
		return make_cmd(c, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endfunction

	// Driver: bursts and gaps; hold the payload while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_walls(pending_cmds.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !hold_sender) begin
					in_valid <= 1'b1;
					cmd <= pending_cmds[0].cmd;
					start_x <= pending_cmds[0].sx;
					start_y <= pending_cmds[0].sy;
					end_x <= pending_cmds[0].ex;
					end_y <= pending_cmds[0].ey;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: periods of none, light and heavy pressure.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 300) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Monitor: compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		seg_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, status", status, -1);
			end else begin
				want = expected_results.pop_front();
				if (status == ST_HIT) hits_seen++;
				if (status == ST_FULL) full_seen++;
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (edge_index !== want.idx) report_mismatch("edge_index", edge_index, want.idx);
				if (hit_x !== want.hx) report_mismatch("hit_x", hit_x, want.hx);
				if (hit_y !== want.hy) report_mismatch("hit_y", hit_y, want.hy);
				if (hit_number !== want.num) report_mismatch("hit_number", hit_number, want.num);
				if (last !== want.last) report_mismatch("last", last, want.last);
			end
		end
	end

	// Stimulus: directed cases, then random adds and raycasts, overfilling the table.
	initial begin
		// raycast into the empty table
		pending_cmds.push_back(make_cmd(CMD_CAST, -32768, -32768, 32767, 32767));
		// extreme walls and a plain cross
		pending_cmds.push_back(make_cmd(CMD_ADD, -32768, 32767, 32767, -32768));
		pending_cmds.push_back(make_cmd(CMD_ADD, 0, -160, 0, 160));
		pending_cmds.push_back(make_cmd(CMD_ADD, -160, 0, 160, 0));
		// degenerate wall (a point) and one touched at an endpoint
		pending_cmds.push_back(make_cmd(CMD_ADD, 5, 5, 5, 5));
		pending_cmds.push_back(make_cmd(CMD_ADD, 100, 100, 100, 300));
		// full diagonal hits the extremes wall
		pending_cmds.push_back(make_cmd(CMD_CAST, -32768, -32768, 32767, 32767));
		// parallel to the horizontal wall, then collinear
		pending_cmds.push_back(make_cmd(CMD_CAST, -100, 50, 100, 50));
		pending_cmds.push_back(make_cmd(CMD_CAST, -300, 0, 300, 0));
		// endpoint touch and a crossing with odd truncation
		pending_cmds.push_back(make_cmd(CMD_CAST, 0, 100, 100, 100));
		pending_cmds.push_back(make_cmd(CMD_CAST, -7, -13, 11, 3));
		pending_cmds.push_back(make_cmd(CMD_CAST, 32767, -32768, -32768, 32767));
		pending_cmds.push_back(make_cmd(CMD_CAST, 0, 0, 0, 0));
		// random part: random adds and casts, with a run of adds that overflows the table
		for (int i = 0; i < 225; i++) begin
			pending_cmds.push_back(rand_cmd(($urandom_range(0, 2) == 0) ? CMD_ADD : CMD_CAST));
			if (i == 150) begin
				for (int k = 0; k < 70; k++) pending_cmds.push_back(rand_cmd(CMD_ADD));
				pending_cmds.push_back(make_cmd(CMD_CAST, -800, -800, 800, 800));
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// pause the sender once until the pipe drains
		wait (pending_cmds.size() < 200);
		@(posedge clk);
		hold_sender <= 1'b1;
		wait (expected_results.size() == 0 && !in_valid);
		repeat (40) @(posedge clk);
		hold_sender <= 1'b0;
		wait (pending_cmds.size() == 0);
		wait (expected_results.size() == 0 && !in_valid);
		repeat (100) @(posedge clk);
		$display("covered %0d result beats, %0d hits, %0d table-full drops", beats_seen,
			hits_seen, full_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
